>>> hdl/ccc_pkg.sv
// Package: widths, shared types and constants of the circumcircle pipeline.
`default_nettype none
package ccc_pkg;

  localparam int CB        = 16;
  localparam int FB        = 16;
  localparam int OB        = 48;
  localparam int DW        = CB + 1;
  localparam int SW        = 2 * DW;
  localparam int PW        = 2 * DW;
  localparam int DDW       = PW + 2;
  localparam int DMW       = DDW;
  localparam int NW        = DW + SW + 2;
  localparam int MW        = NW;
  localparam int QW        = MW + FB;
  localparam int VW        = QW + 2;
  localparam int HB        = OB / 2;
  localparam int RW        = OB + 1;
  localparam int RDW       = 2 * RW;
  localparam int RMW       = RW + 3;
  localparam int FRONT_LAT = 5;
  localparam int LAT       = FRONT_LAT + QW + 3 + RW + 1;

  localparam logic signed [VW-1:0] CMAX = (VW'(1) << (OB - 1)) - VW'(1);
  localparam logic signed [VW-1:0] CMIN = -(VW'(1) << (OB - 1));

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    coord_t          ax;
    coord_t          ay;
    logic [MW-1:0]   nxm;
    logic [MW-1:0]   nym;
    logic [DMW-1:0]  dm;
    logic            negx;
    logic            negy;
    logic            deg;
  } front_t;

endpackage
`default_nettype wire

>>> hdl/ccc_if.sv
// Interfaces: input and result channels with valid/ready transfer.
`default_nettype none
interface ccc_in_if;
  import ccc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t ax;
  coord_t ay;
  coord_t bx;
  coord_t by;
  coord_t cx;
  coord_t cy;
  modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface ccc_out_if;
  import ccc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [OB-1:0] center_x;
  logic signed [OB-1:0] center_y;
  logic [OB-1:0]        radius;
  logic                 degenerate;
  logic                 saturated;
  modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                  input ready);
  modport sink (input valid, center_x, center_y, radius, degenerate, saturated,
                output ready);
endinterface
`default_nettype wire

>>> hdl/ccc_front.sv
// Front stages: differences, squares, cross products, numerators and magnitudes.
`default_nettype none
module ccc_front (
  input  logic            clk_i,
  input  logic            en_i,
  input  ccc_pkg::coord_t ax_i,
  input  ccc_pkg::coord_t ay_i,
  input  ccc_pkg::coord_t bx_i,
  input  ccc_pkg::coord_t by_i,
  input  ccc_pkg::coord_t cx_i,
  input  ccc_pkg::coord_t cy_i,
  output ccc_pkg::front_t res_o
);
  import ccc_pkg::*;

  typedef logic signed [DW-1:0] diff_t;

  coord_t ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q, ax4_q, ay4_q;
  diff_t  x2_1_q, y2_1_q, x3_1_q, y3_1_q;
  diff_t  x2_2_q, y2_2_q, x3_2_q, y3_2_q;
  logic [SW-1:0]          s2_2_q, s3_2_q;
  logic signed [PW-1:0]   p1_2_q, p2_2_q;
  logic signed [DDW-1:0]  d3_q, d4_q;
  logic signed [NW-2:0]   t1_q, t2_q, t3_q, t4_q;
  logic signed [NW-1:0]   nx4_q, ny4_q;
  front_t                 res_q;

  logic signed [PW-1:0]   x2sq, y2sq, x3sq, y3sq, p1_d, p2_d;
  logic signed [SW:0]     s2s, s3s;
  logic signed [NW-1:0]   nxneg, nyneg;
  logic signed [DDW-1:0]  dneg_v;
  logic                   dneg;

  assign x2sq   = x2_1_q * x2_1_q;
  assign y2sq   = y2_1_q * y2_1_q;
  assign x3sq   = x3_1_q * x3_1_q;
  assign y3sq   = y3_1_q * y3_1_q;
  assign p1_d   = x2_1_q * y3_1_q;
  assign p2_d   = x3_1_q * y2_1_q;
  assign s2s    = $signed({1'b0, s2_2_q});
  assign s3s    = $signed({1'b0, s3_2_q});
  assign nxneg  = -nx4_q;
  assign nyneg  = -ny4_q;
  assign dneg_v = -d4_q;
  assign dneg   = d4_q[DDW-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax1_q  <= ax_i;
      ay1_q  <= ay_i;
      x2_1_q <= diff_t'(bx_i) - diff_t'(ax_i);
      y2_1_q <= diff_t'(by_i) - diff_t'(ay_i);
      x3_1_q <= diff_t'(cx_i) - diff_t'(ax_i);
      y3_1_q <= diff_t'(cy_i) - diff_t'(ay_i);

      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      x2_2_q <= x2_1_q;
      y2_2_q <= y2_1_q;
      x3_2_q <= x3_1_q;
      y3_2_q <= y3_1_q;
      s2_2_q <= $unsigned(x2sq) + $unsigned(y2sq);
      s3_2_q <= $unsigned(x3sq) + $unsigned(y3sq);
      p1_2_q <= p1_d;
      p2_2_q <= p2_d;

      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      d3_q   <= (DDW'(p1_2_q) - DDW'(p2_2_q)) <<< 1;
      t1_q   <= y3_2_q * s2s;
      t2_q   <= y2_2_q * s3s;
      t3_q   <= x2_2_q * s3s;
      t4_q   <= x3_2_q * s2s;

      ax4_q  <= ax3_q;
      ay4_q  <= ay3_q;
      d4_q   <= d3_q;
      nx4_q  <= NW'(t1_q) - NW'(t2_q);
      ny4_q  <= NW'(t3_q) - NW'(t4_q);

      res_q.ax   <= ax4_q;
      res_q.ay   <= ay4_q;
      res_q.nxm  <= nx4_q[NW-1] ? MW'(nxneg) : MW'(nx4_q);
      res_q.nym  <= ny4_q[NW-1] ? MW'(nyneg) : MW'(ny4_q);
      res_q.dm   <= dneg ? DMW'(dneg_v) : DMW'(d4_q);
      res_q.negx <= nx4_q[NW-1] ^ dneg;
      res_q.negy <= ny4_q[NW-1] ^ dneg;
      res_q.deg  <= (d4_q == '0);
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

>>> hdl/ccc_div.sv
// Divider: restoring division pipeline, one quotient bit per stage.
`default_nettype none
module ccc_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ccc_pkg::MW-1:0]   n_i,
  input  logic [ccc_pkg::DMW-1:0]  d_i,
  output logic [ccc_pkg::QW-1:0]   q_o
);
  import ccc_pkg::*;

  logic [QW-1:0]  n_q [QW];
  logic [QW-1:0]  q_q [QW];
  logic [DMW-1:0] r_q [QW];
  logic [DMW-1:0] d_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW-1:0]  n_in, q_in;
    logic [DMW-1:0] r_in, d_in;
    logic [DMW:0]   t, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign n_in = QW'(n_i) << FB;
      assign q_in = '0;
      assign r_in = '0;
      assign d_in = d_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign q_in = q_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
    end

    assign t    = {r_in, n_in[QW-1]};
    assign diff = t - {1'b0, d_in};
    assign ge   = (t >= {1'b0, d_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_in << 1;
        r_q[k] <= ge ? diff[DMW-1:0] : t[DMW-1:0];
        d_q[k] <= d_in;
        q_q[k] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule
`default_nettype wire

>>> hdl/ccc_sqrt.sv
// Square root: digit-by-digit integer square root pipeline, one root bit per stage.
`default_nettype none
module ccc_sqrt (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ccc_pkg::RDW-1:0]  rad_i,
  output logic [ccc_pkg::RW-1:0]   root_o
);
  import ccc_pkg::*;

  logic [RDW-1:0] rad_q  [RW];
  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RDW-1:0] rad_in;
    logic [RMW-1:0] rem_in, t, trial;
    logic [RW-1:0]  root_in;
    logic           ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign t     = {rem_in[RMW-3:0], rad_in[RDW-1:RDW-2]};
    assign trial = RMW'({root_in, 2'b01});
    assign ge    = (t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_in << 2;
        rem_q[k]  <= ge ? (t - trial) : t;
        root_q[k] <= {root_in[RW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule
`default_nettype wire

>>> hdl/circumcircle_of_three_points_top.sv
// Top level: circumcircle centre and radius of three points, fully pipelined.
// Stages from input transfer to result: front, divider, centre and square,
// square root, output register; divider and square root are one bit per stage.
// Throughput: one item per cycle while out_o.ready is high or no result is held.
// Reset clears the valid bits only; the datapath registers are not reset.
`default_nettype none
module circumcircle_of_three_points_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ccc_in_if.sink     in_i,
  ccc_out_if.source  out_o
);
  import ccc_pkg::*;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    logic   negx;
    logic   negy;
    logic   deg;
  } dside_t;

  typedef struct packed {
    logic [OB-1:0] cx;
    logic [OB-1:0] cy;
    logic          sat;
    logic          ovf;
    logic          deg;
  } rside_t;

  logic           en;
  logic [LAT-1:0] v_q;
  front_t         fr;
  logic [QW-1:0]  qx, qy;
  dside_t         ds_q [QW];
  dside_t         ds_end;

  logic signed [VW-1:0] vx_d, vy_d, vx_q, vy_q;
  logic                 ovf1_q, deg1_q;
  logic [2*HB-1:0]      hhx_q, hlx_q, llx_q, hhy_q, hly_q, lly_q;
  logic [RDW-1:0]       sqx_q, sqy_q, sq_q;
  rside_t               side2_q, side3_q;
  rside_t               rs_q [RW];
  rside_t               rs_end;
  logic [RW-1:0]        root;

  logic [OB-1:0]        cx2_d, cy2_d;
  logic                 satx, saty;

  logic signed [OB-1:0] cx_o_q, cy_o_q;
  logic [OB-1:0]        rad_o_q;
  logic                 deg_o_q, sat_o_q;

  assign en         = !v_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_i.valid};
    end
  end

  ccc_front u_front (
    .clk_i (clk_i),
    .en_i  (en),
    .ax_i  (in_i.ax),
    .ay_i  (in_i.ay),
    .bx_i  (in_i.bx),
    .by_i  (in_i.by),
    .cx_i  (in_i.cx),
    .cy_i  (in_i.cy),
    .res_o (fr)
  );

  ccc_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (fr.nxm),
    .d_i   (fr.dm),
    .q_o   (qx)
  );

  ccc_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (fr.nym),
    .d_i   (fr.dm),
    .q_o   (qy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ds_q[0] <= '{ax: fr.ax, ay: fr.ay, negx: fr.negx, negy: fr.negy, deg: fr.deg};
      for (int i = 1; i < QW; i++) begin
        ds_q[i] <= ds_q[i-1];
      end
    end
  end

  assign ds_end = ds_q[QW-1];

  assign vx_d = (VW'($signed(ds_end.ax)) <<< FB)
              + (ds_end.negx ? -$signed(VW'(qx)) : $signed(VW'(qx)));
  assign vy_d = (VW'($signed(ds_end.ay)) <<< FB)
              + (ds_end.negy ? -$signed(VW'(qy)) : $signed(VW'(qy)));

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (vx_q > CMAX) begin
      cx2_d = CMAX[OB-1:0];
      satx  = 1'b1;
    end else if (vx_q < CMIN) begin
      cx2_d = CMIN[OB-1:0];
      satx  = 1'b1;
    end else begin
      cx2_d = vx_q[OB-1:0];
    end
    if (vy_q > CMAX) begin
      cy2_d = CMAX[OB-1:0];
      saty  = 1'b1;
    end else if (vy_q < CMIN) begin
      cy2_d = CMIN[OB-1:0];
      saty  = 1'b1;
    end else begin
      cy2_d = vy_q[OB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q   <= vx_d;
      vy_q   <= vy_d;
      ovf1_q <= (|qx[QW-1:OB]) || (|qy[QW-1:OB]);
      deg1_q <= ds_end.deg;
      hhx_q  <= qx[OB-1:HB] * qx[OB-1:HB];
      hlx_q  <= qx[OB-1:HB] * qx[HB-1:0];
      llx_q  <= qx[HB-1:0] * qx[HB-1:0];
      hhy_q  <= qy[OB-1:HB] * qy[OB-1:HB];
      hly_q  <= qy[OB-1:HB] * qy[HB-1:0];
      lly_q  <= qy[HB-1:0] * qy[HB-1:0];

      side2_q <= '{cx: cx2_d, cy: cy2_d, sat: satx || saty, ovf: ovf1_q, deg: deg1_q};
      sqx_q   <= (RDW'(hhx_q) << OB) + (RDW'(hlx_q) << (HB + 1)) + RDW'(llx_q);
      sqy_q   <= (RDW'(hhy_q) << OB) + (RDW'(hly_q) << (HB + 1)) + RDW'(lly_q);

      side3_q <= side2_q;
      sq_q    <= sqx_q + sqy_q;

      rs_q[0] <= side3_q;
      for (int i = 1; i < RW; i++) begin
        rs_q[i] <= rs_q[i-1];
      end
    end
  end

  ccc_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq_q),
    .root_o (root)
  );

  assign rs_end = rs_q[RW-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rs_end.deg) begin
        cx_o_q  <= '0;
        cy_o_q  <= '0;
        rad_o_q <= '0;
        deg_o_q <= 1'b1;
        sat_o_q <= 1'b0;
      end else begin
        cx_o_q  <= rs_end.cx;
        cy_o_q  <= rs_end.cy;
        rad_o_q <= (rs_end.ovf || root[RW-1]) ? {OB{1'b1}} : root[OB-1:0];
        deg_o_q <= 1'b0;
        sat_o_q <= rs_end.sat || rs_end.ovf || root[RW-1];
      end
    end
  end

  assign out_o.valid      = v_q[LAT-1];
  assign out_o.center_x   = cx_o_q;
  assign out_o.center_y   = cy_o_q;
  assign out_o.radius     = rad_o_q;
  assign out_o.degenerate = deg_o_q;
  assign out_o.saturated  = sat_o_q;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |->
      out_o.center_x == '0 && out_o.center_y == '0 && out_o.radius == '0 &&
      !out_o.saturated)
    else $error("degenerate result with nonzero fields");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during stall");
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> v_q[0] == $past(in_i.valid))
    else $error("input transfer not captured in first stage");
`endif

endmodule
`default_nettype wire

>>> verif/circumcircle_checker.sv
// Checker: predicts the circumcircle of each accepted triangle and compares the results.
`default_nettype none
module circumcircle_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccc_in_if         in_mon,
  ccc_out_if        out_mon,
  output int        fail_count_o,
  output int        pending_o
);
  import ccc_pkg::*;

  typedef struct packed {
    logic signed [OB-1:0] center_x;
    logic signed [OB-1:0] center_y;
    logic [OB-1:0]        radius;
    logic                 degenerate;
    logic                 saturated;
  } circle_t;

  typedef logic signed [127:0] wide_t;

  circle_t circles_q[$];
  int      fails;

  function automatic wide_t clip_centre(input wide_t v, inout logic sat);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (OB - 1)) - 1;
    lo = -(wide_t'(1) <<< (OB - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic circle_t circumcircle(input coord_t ax, ay, bx, by, cx, cy);
    circle_t    res;
    wide_t      x2, y2, x3, y3, s2, s3, d, nx, ny, dm, qx, qy, vx, vy;
    logic [127:0] sq, t, r;
    logic       sat;
    logic [127:0] omask;
    omask = (128'd1 << OB) - 1;
    res = '0;
    sat = 1'b0;
    x2 = wide_t'(bx) - wide_t'(ax);
    y2 = wide_t'(by) - wide_t'(ay);
    x3 = wide_t'(cx) - wide_t'(ax);
    y3 = wide_t'(cy) - wide_t'(ay);
    s2 = x2 * x2 + y2 * y2;
    s3 = x3 * x3 + y3 * y3;
    d  = 2 * (x2 * y3 - x3 * y2);
    if (d == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    nx = y3 * s2 - y2 * s3;
    ny = x2 * s3 - x3 * s2;
    if (d < 0) begin
      nx = -nx;
      ny = -ny;
      dm = -d;
    end else begin
      dm = d;
    end
    qx = ((nx < 0 ? -nx : nx) <<< FB) / dm;
    qy = ((ny < 0 ? -ny : ny) <<< FB) / dm;
    vx = (wide_t'(ax) <<< FB) + (nx < 0 ? -qx : qx);
    vy = (wide_t'(ay) <<< FB) + (ny < 0 ? -qy : qy);
    vx = clip_centre(vx, sat);
    vy = clip_centre(vy, sat);
    res.center_x = vx[OB-1:0];
    res.center_y = vy[OB-1:0];
    r = '0;
    if (qx > wide_t'(omask) || qy > wide_t'(omask)) begin
      sat = 1'b1;
      r = omask;
    end else begin
      sq = qx * qx + qy * qy;
      for (int b = OB; b >= 0; b--) begin
        t = r | (128'd1 << b);
        if (t * t <= sq) r = t;
      end
      if (r > omask) begin
        sat = 1'b1;
        r = omask;
      end
    end
    res.radius    = r[OB-1:0];
    res.saturated = sat;
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    circle_t want;
    if (!rst_ni) begin
      fails <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (circles_q.size() == 0) begin
          $error("result transfer with no triangle outstanding");
          fails <= fails + 1;
        end else begin
          want = circles_q.pop_front();
          if (out_mon.center_x !== want.center_x ||
              out_mon.center_y !== want.center_y ||
              out_mon.radius !== want.radius ||
              out_mon.degenerate !== want.degenerate ||
              out_mon.saturated !== want.saturated)
            fails <= fails + 1;
          if (out_mon.center_x !== want.center_x)
            $error("center_x expected %0d actual %0d", want.center_x, out_mon.center_x);
          if (out_mon.center_y !== want.center_y)
            $error("center_y expected %0d actual %0d", want.center_y, out_mon.center_y);
          if (out_mon.radius !== want.radius)
            $error("radius expected %0d actual %0d", want.radius, out_mon.radius);
          if (out_mon.degenerate !== want.degenerate)
            $error("degenerate expected %0b actual %0b", want.degenerate, out_mon.degenerate);
          if (out_mon.saturated !== want.saturated)
            $error("saturated expected %0b actual %0b", want.saturated, out_mon.saturated);
        end
      end
      if (in_mon.valid && in_mon.ready)
        circles_q.push_back(circumcircle(in_mon.ax, in_mon.ay, in_mon.bx,
                                         in_mon.by, in_mon.cx, in_mon.cy));
    end
  end

  assign fail_count_o = fails + circles_q.size();
  assign pending_o    = circles_q.size();
endmodule
`default_nettype wire

>>> verif/circumcircle_of_three_points_top_tb.sv
// Testbench top: drives triangles into the circumcircle block and reports the verdict.
`default_nettype none
module circumcircle_of_three_points_top_tb;
  import ccc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic in_fire_q = 1'b0;

  ccc_in_if  in_if ();
  ccc_out_if out_if ();

  circumcircle_of_three_points_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  circumcircle_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always_ff @(posedge clk_i) begin
    in_fire_q <= in_if.valid && in_if.ready;
    cycles    <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_if.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send(input coord_t ax, ay, bx, by, cx, cy);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.ax <= ax;
    in_if.ay <= ay;
    in_if.bx <= bx;
    in_if.by <= by;
    in_if.cx <= cx;
    in_if.cy <= cy;
    do @(negedge clk_i); while (!in_fire_q);
  endtask

  function automatic coord_t rnd_coord(input int span);
    if (span >= 32768) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic send_random();
    coord_t ax, ay, bx, by, cx, cy;
    int     k, span;
    k = $urandom_range(99);
    span = (k < 40) ? 32768 : (k < 70 ? 200 : 8);
    ax = rnd_coord(span);
    ay = rnd_coord(span);
    bx = rnd_coord(span);
    by = rnd_coord(span);
    if (k < 85) begin
      cx = rnd_coord(span);
      cy = rnd_coord(span);
    end else begin
      // collinear or nearly so: third point on the line through the first two
      cx = coord_t'(bx + (bx - ax) * $signed($urandom_range(2)));
      cy = coord_t'(by + (by - ay) * $signed($urandom_range(2)));
      if (k >= 93) cx = coord_t'(cx + $signed($urandom_range(2)) - 1);
    end
    send(ax, ay, bx, by, cx, cy);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.ax = '0;
    in_if.ay = '0;
    in_if.bx = '0;
    in_if.by = '0;
    in_if.cx = '0;
    in_if.cy = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(0, 0, 1, 0, 0, 1);
    send(32767, 32767, -32768, -32768, 32767, -32768);
    send(-32768, -32768, -32768, -32768, -32768, -32768);
    send(5, 5, 5, 5, 9, -3);
    send(1, 2, 3, 4, 5, 6);
    send(-32768, 0, 0, 0, 32767, 0);
    send(7, 0, 7, 9, -4, 3);
    send(-32768, -32768, 32767, 32767, 32767, 32766);
    send(-32768, 32767, 32767, -32768, 32766, -32768);
    send(-32768, 0, 32767, 1, 0, 0);
    send(32767, -32768, -32768, 32767, 0, 1);
    send(-1, -1, 0, 0, 1, 0);
    send(100, -200, -300, 400, 250, 250);
    send(32767, 32767, 32767, -32768, -32768, 32767);
    send(0, 0, 32767, 32767, -32768, 32767);
    send(-21846, 21845, 21845, -21846, -10923, 10922);

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1 || phase == 3) ? (phase == 3 ? 8 : 62) : 0;
      stall_pct = (phase == 2 || phase == 3) ? (phase == 3 ? 8 : 62) : 0;
      for (int i = 0; i < 185; i++) send_random();
    end

    in_if.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/ccc_pkg.sv
hdl/ccc_if.sv
hdl/ccc_front.sv
hdl/ccc_div.sv
hdl/ccc_sqrt.sv
hdl/circumcircle_of_three_points_top.sv
verif/circumcircle_checker.sv
verif/circumcircle_of_three_points_top_tb.sv
